// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checked while out of reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, checked while out of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/qte_pkg.sv =====
// Types, constants and helper functions of the quaternion to Euler angle converter.
package qte_pkg;

    localparam int TW = 44;          // term width
    localparam int CW = 46;          // CORDIC x/y width
    localparam int AW = 27;          // angle width, 1/65536 degree
    localparam int TAB_LEN = 24;
    localparam int ROLL_LIM = 23040;
    localparam int PITCH_LIM = 11520;
    localparam logic signed [AW-1:0] DEG90 = AW'(5898240);
    localparam logic [0:0] REG_ORDER = 1'b0;

    typedef enum logic [1:0] {
        ORD_XYZ = 2'd0,
        ORD_YZX = 2'd1,
        ORD_ZYX = 2'd2,
        ORD_ZXY = 2'd3
    } rot_order_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 zero;
    } cordic_t;

    function automatic logic signed [AW-1:0] atan_entry(input int idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:  v = AW'(2949120);
            1:  v = AW'(1740967);
            2:  v = AW'(919879);
            3:  v = AW'(466945);
            4:  v = AW'(234379);
            5:  v = AW'(117304);
            6:  v = AW'(58666);
            7:  v = AW'(29335);
            8:  v = AW'(14668);
            9:  v = AW'(7334);
            10: v = AW'(3667);
            11: v = AW'(1833);
            12: v = AW'(917);
            13: v = AW'(458);
            14: v = AW'(229);
            15: v = AW'(115);
            16: v = AW'(57);
            17: v = AW'(29);
            18: v = AW'(14);
            19: v = AW'(7);
            20: v = AW'(4);
            21: v = AW'(2);
            22: v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Quadrant fold: vectors with negative x are turned by +-90 degrees.
    function automatic cordic_t pre_rot(input logic signed [TW-1:0] y,
                                        input logic signed [TW-1:0] x);
        cordic_t c;
        logic signed [CW-1:0] xe, ye;
        xe = CW'(x);
        ye = CW'(y);
        c.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            if (y >= 0) begin
                c.x = ye; c.y = -xe; c.z = DEG90;
            end else begin
                c.x = -ye; c.y = xe; c.z = -DEG90;
            end
        end else begin
            c.x = xe; c.y = ye; c.z = '0;
        end
        return c;
    endfunction

    // 1/65536 degree to 1/128 degree with rounding, then saturation.
    function automatic logic signed [15:0] to_out(input logic signed [AW-1:0] a,
                                                  input int lim);
        logic signed [AW:0] s;
        logic signed [AW:0] l;
        s = ((AW+1)'(a) + (AW+1)'(256)) >>> 9;
        l = (AW+1)'(lim);
        if (s > l) s = l;
        if (s < -l) s = -l;
        return s[15:0];
    endfunction

endpackage

// ===== rtl/quaternion_to_euler_angles.sv =====
// Top level: quaternion in, roll, pitch and yaw out, fully pipelined.
// One quaternion item (w, x, y, z, signed, 1.0 = 2^FRAC_BITS) enters per clock and one
// angle item leaves per clock while the pipe advances; an item passes the product, term,
// square and difference registers, the 31-cell square root chain, the fold register, the
// CORDIC cell chain (three lanes side by side) and the output register. The whole pipe
// advances together: it moves whenever the output register is empty or being taken, so a
// waiting result stalls the pipe and s_tready drops with it. rotation_order (APB address 0)
// selects the term ordering and is to be written only while no item is in flight. Angles
// are in 1/128 degree, roll and yaw saturated to +-23040, pitch to +-11520.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll[15:0], pitch[30:16], yaw[46:31], zero pad [47]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qte_pkg::*;
    `include "assert_macros.svh"

    localparam int NST = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
    localparam int SQ_N = 31;
    localparam int P_PREP = 4 + SQ_N;       // stage index of the fold register
    localparam int L = P_PREP + NST + 2;    // total pipeline depth
    localparam int SH = 30 - 2 * FRAC_BITS;
    localparam int SHL = (SH > 0) ? SH : 0;
    localparam int SHR = (SH < 0) ? -SH : 0;
    localparam int PW = 4 * TW + 32;
    localparam logic signed [TW-1:0] HALF = TW'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic signed [TW-1:0] ONE  = TW'(1) <<< (2 * FRAC_BITS);
    localparam logic [60:0] SQ_TOP = 61'(1) << 60;

    // configuration
    rot_order_t order_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ORDER);
    assign prdata = (paddr[2] == REG_ORDER) ? {30'd0, order_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORD_XYZ;
        end else if (cfg_wr) begin
            order_reg <= rot_order_t'(pwdata[1:0]);
        end
    end

    // pipe control: one shared advance for every stage
    logic [L-1:0] vld_reg;
    logic         en;

    assign en       = !vld_reg[L-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[L-2:0], s_tvalid};
        end
    end

    // stage 1: pairwise products
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] pwx_reg, pwy_reg, pwz_reg, pxx_reg, pyy_reg, pzz_reg;
    logic signed [31:0] pxy_reg, pxz_reg, pyz_reg;

    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (en) begin
            pwx_reg <= qw * qx;
            pwy_reg <= qw * qy;
            pwz_reg <= qw * qz;
            pxx_reg <= qx * qx;
            pyy_reg <= qy * qy;
            pzz_reg <= qz * qz;
            pxy_reg <= qx * qy;
            pxz_reg <= qx * qz;
            pyz_reg <= qy * qz;
        end
    end

    // stage 2: term selection, pitch term doubled, clamped and moved to 30 fraction bits
    logic signed [TW-1:0] wx, wy, wz, xx, yy, zz, xy, xz, yz;
    logic signed [TW-1:0] t0_next, t1_next, t3_next, t4_next, d, tc, tsh;
    logic signed [TW-1:0] t0_reg, t1_reg, t3_reg, t4_reg;
    logic signed [31:0]   tp_reg;

    always_comb begin
        wx = TW'(pwx_reg); wy = TW'(pwy_reg); wz = TW'(pwz_reg);
        xx = TW'(pxx_reg); yy = TW'(pyy_reg); zz = TW'(pzz_reg);
        xy = TW'(pxy_reg); xz = TW'(pxz_reg); yz = TW'(pyz_reg);
        case (order_reg)
            ORD_YZX: begin
                t0_next = wy + xz; t1_next = HALF - (yy + zz); d = wz - xy;
                t3_next = wx + yz; t4_next = HALF - (xx + zz);
            end
            ORD_ZYX: begin
                t0_next = wz - xy; t1_next = HALF - (yy + zz); d = wy - xz;
                t3_next = wx - yz; t4_next = HALF - (xx + yy);
            end
            ORD_ZXY: begin
                t0_next = wz + xy; t1_next = HALF - (xx + zz); d = wx - yz;
                t3_next = wy + xz; t4_next = HALF - (xx + yy);
            end
            default: begin
                t0_next = wx + yz; t1_next = HALF - (xx + yy); d = wy - xz;
                t3_next = wz + xy; t4_next = HALF - (yy + zz);
            end
        endcase
        tc = d <<< 1;
        if (tc > ONE)  tc = ONE;
        if (tc < -ONE) tc = -ONE;
        tsh = (tc <<< SHL) >>> SHR;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            t3_reg <= t3_next;
            t4_reg <= t4_next;
            tp_reg <= tsh[31:0];
        end
    end

    // stage 3: square of the pitch term; stage 4: 2^60 - t^2
    logic signed [63:0]   tt_reg;
    logic [PW-1:0]        pl3_reg, pl4_reg;
    logic [60:0]          v4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tt_reg  <= tp_reg * tp_reg;
            pl3_reg <= {t0_reg, t1_reg, t3_reg, t4_reg, tp_reg};
            v4_reg  <= SQ_TOP - tt_reg[60:0];
            pl4_reg <= pl3_reg;
        end
    end

    // square root chain: cosine of pitch
    logic [60:0]   sq_v  [0:SQ_N];
    logic [60:0]   sq_r  [0:SQ_N];
    logic [PW-1:0] sq_pl [0:SQ_N];

    assign sq_v[0]  = v4_reg;
    assign sq_r[0]  = '0;
    assign sq_pl[0] = pl4_reg;

    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        qte_sqrt_cell #(.STAGE(g), .PW(PW)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .v_in   (sq_v[g]),
            .r_in   (sq_r[g]),
            .pl_in  (sq_pl[g]),
            .v_out  (sq_v[g+1]),
            .r_out  (sq_r[g+1]),
            .pl_out (sq_pl[g+1])
        );
    end

    // quadrant fold of the three lanes
    logic signed [TW-1:0] f_t0, f_t1, f_t3, f_t4, f_tp, f_c;
    cordic_t rl_c [0:NST];
    cordic_t pt_c [0:NST];
    cordic_t yw_c [0:NST];

    assign f_t0 = sq_pl[SQ_N][PW-1 -: TW];
    assign f_t1 = sq_pl[SQ_N][PW-TW-1 -: TW];
    assign f_t3 = sq_pl[SQ_N][PW-2*TW-1 -: TW];
    assign f_t4 = sq_pl[SQ_N][PW-3*TW-1 -: TW];
    assign f_tp = TW'($signed(sq_pl[SQ_N][31:0]));
    assign f_c  = $signed(sq_r[SQ_N][TW-1:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            rl_c[0] <= pre_rot(f_t0, f_t1);
            pt_c[0] <= pre_rot(f_tp, f_c);
            yw_c[0] <= pre_rot(f_t3, f_t4);
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_cordic
        qte_cordic_cell #(.STAGE(k)) u_roll (
            .aclk(aclk), .en(en), .d_in(rl_c[k]), .d_out(rl_c[k+1]));
        qte_cordic_cell #(.STAGE(k)) u_pitch (
            .aclk(aclk), .en(en), .d_in(pt_c[k]), .d_out(pt_c[k+1]));
        qte_cordic_cell #(.STAGE(k)) u_yaw (
            .aclk(aclk), .en(en), .d_in(yw_c[k]), .d_out(yw_c[k+1]));
    end

    // output register: rounding to 1/128 degree and saturation
    logic signed [AW-1:0] a_roll, a_pitch, a_yaw;
    logic signed [15:0]   o_roll, o_pitch, o_yaw;
    logic [47:0]          out_reg;

    always_comb begin
        a_roll  = rl_c[NST].zero ? '0 : rl_c[NST].z;
        a_pitch = pt_c[NST].zero ? '0 : pt_c[NST].z;
        a_yaw   = yw_c[NST].zero ? '0 : yw_c[NST].z;
        o_roll  = to_out(a_roll, ROLL_LIM);
        o_pitch = to_out(a_pitch, PITCH_LIM);
        o_yaw   = to_out(a_yaw, ROLL_LIM);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {1'b0, o_yaw, o_pitch[14:0], o_roll};
        end
    end

    assign m_tdata = out_reg;

    // checks
    `ASSERT_IMPLIES(a_roll_range, aclk, aresetn, m_tvalid,
        ($signed(m_tdata[15:0]) <= 16'sd23040) && ($signed(m_tdata[15:0]) >= -16'sd23040))
    `ASSERT_IMPLIES(a_pitch_range, aclk, aresetn, m_tvalid,
        ($signed(m_tdata[30:16]) <= 15'sd11520) && ($signed(m_tdata[30:16]) >= -15'sd11520))
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, !en, $stable(vld_reg))

endmodule

// ===== rtl/qte_sqrt_cell.sv =====
// One restoring step of the pipelined integer square root, with payload pass-through.
module qte_sqrt_cell #(
    parameter int STAGE = 0,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [60:0]   v_in,
    input  logic [60:0]   r_in,
    input  logic [PW-1:0] pl_in,
    output logic [60:0]   v_out,
    output logic [60:0]   r_out,
    output logic [PW-1:0] pl_out
);
    localparam logic [60:0] BIT = 61'(1) << (60 - 2 * STAGE);

    logic [60:0] v_reg, v_next, r_reg, r_next, sum;
    logic [PW-1:0] pl_reg;

    always_comb begin
        sum = r_in + BIT;
        if (v_in >= sum) begin
            v_next = v_in - sum;
            r_next = (r_in >> 1) + BIT;
        end else begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg  <= v_next;
            r_reg  <= r_next;
            pl_reg <= pl_in;
        end
    end

    assign v_out  = v_reg;
    assign r_out  = r_reg;
    assign pl_out = pl_reg;
endmodule

// ===== rtl/qte_cordic_cell.sv =====
// One vectoring micro-rotation of the CORDIC chain.
module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  qte_pkg::cordic_t  d_in,
    output qte_pkg::cordic_t  d_out
);
    import qte_pkg::*;

    cordic_t d_reg, d_next;
    logic signed [CW-1:0] xs, ys;

    always_comb begin
        xs = d_in.x >>> STAGE;
        ys = d_in.y >>> STAGE;
        d_next = d_in;
        if (!d_in.y[CW-1]) begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + atan_entry(STAGE);
        end else begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - atan_entry(STAGE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
